// ===== rtl/gosc_pkg.sv =====
// Shared types and constants for the grid obstacle store.
`timescale 1ns / 1ps
`default_nettype none

package gosc_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned KeyW         = 2 * CoordW;
  localparam int unsigned CountOutW    = 7;
  localparam int unsigned CfgIdxW      = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_MIN_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_X = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_Y = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_Y = 2'd3;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [CoordW-1:0]  x_coord;
    logic signed [CoordW-1:0]  y_coord;
  } in_t;

  typedef struct packed {
    logic                  blocked;
    status_e               status;
    logic [CountOutW-1:0]  entry_count;
  } out_t;

  // Request traveling down the cell chain; key holds y in the high half.
  typedef struct packed {
    logic             active;
    cmd_e             cmd;
    logic [KeyW-1:0]  key;
    logic             hit;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/grid_obstacle_store_and_check.sv =====
// Top level of the grid obstacle store: cell chain, bounds registers and result stage.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken at the rising edge where start_i is high and busy_o is low.
// It then walks the chain of Capacity slot cells, one cell per clock, so the
// lowest slot always sees it first. The result appears on rsp_o with done_o high
// for exactly one cycle, registered into done_q and rsp_q as the request leaves
// the last cell, and is taken at the edge that ends that cycle. busy_o drops at
// the edge where done_o rises, so the next request may be given while the result
// is shown; a new request is not taken while one is still in the chain. The
// receiver cannot stall the result. Bounds registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only while busy_o
// is low, which the block itself does not enforce.
module grid_obstacle_store_and_check #(
  parameter int unsigned Capacity = gosc_pkg::CAPACITY_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire gosc_pkg::in_t           req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output gosc_pkg::out_t               rsp_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [gosc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gosc_pkg::CoordW-1:0]  cfg_wdata_i
);
  import gosc_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic signed [CoordW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic                     busy_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     done_q;
  out_t                     rsp_q, rsp_d;
  logic                     accept;
  tok_t                     chain [Capacity+1];
  tok_t                     last;
  logic signed [CoordW-1:0] last_x, last_y;
  logic                     out_of_bounds;
  logic [CntW+CountOutW-1:0] cnt_ext;

  assign accept = start_i && !busy_q;

  assign chain[0] = '{active: accept,
                      cmd:    req_i.cmd,
                      key:    {req_i.y_coord, req_i.x_coord},
                      hit:    1'b0};

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    gosc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign last   = chain[Capacity];
  assign last_x = $signed(last.key[CoordW-1:0]);
  assign last_y = $signed(last.key[KeyW-1:CoordW]);

  assign out_of_bounds = (last_x < min_x_q) || (last_x > max_x_q) ||
                         (last_y < min_y_q) || (last_y > max_y_q);

  always_comb begin
    cnt_d         = cnt_q;
    rsp_d.blocked = 1'b0;
    rsp_d.status  = ST_OK;
    unique case (last.cmd)
      CMD_INSERT: begin
        if (last.hit) begin
          cnt_d = cnt_q + CntW'(1);
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (last.hit) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      CMD_QUERY: begin
        rsp_d.blocked = out_of_bounds || last.hit;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    cnt_ext           = {{CountOutW{1'b0}}, cnt_d};
    rsp_d.entry_count = cnt_ext[CountOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
    end else begin
      done_q <= last.active;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.active) begin
        busy_q <= 1'b0;
      end
      if (last.active) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIN_X: min_x_q <= $signed(cfg_wdata_i);
          REG_MAX_X: max_x_q <= $signed(cfg_wdata_i);
          REG_MIN_Y: min_y_q <= $signed(cfg_wdata_i);
          REG_MAX_Y: max_y_q <= $signed(cfg_wdata_i);
          default:   min_x_q <= min_x_q;
        endcase
      end
    end
  end

  // capture the result shown while done_o is high; it holds until the next one
  always_ff @(posedge clk_i) begin
    if (last.active) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/gosc_cell.sv =====
// One storage cell of the obstacle chain: a slot plus the request register to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module gosc_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gosc_pkg::tok_t tok_i,
  output gosc_pkg::tok_t     tok_o
);
  import gosc_pkg::*;

  logic             valid_q, valid_d;
  logic [KeyW-1:0]  coord_q;
  logic             coord_we;
  logic             match;
  tok_t             tok_q, tok_d;

  assign match = valid_q && (coord_q == tok_i.key);

  always_comb begin
    tok_d    = tok_i;
    valid_d  = valid_q;
    coord_we = 1'b0;
    if (tok_i.active) begin
      unique case (tok_i.cmd)
        CMD_INSERT: begin
          // claim the first free slot seen by this request
          if (!tok_i.hit && !valid_q) begin
            valid_d   = 1'b1;
            coord_we  = 1'b1;
            tok_d.hit = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (!tok_i.hit && match) begin
            valid_d   = 1'b0;
            tok_d.hit = 1'b1;
          end
        end
        CMD_CLEAR: begin
          valid_d = 1'b0;
        end
        CMD_QUERY: begin
          if (match) begin
            tok_d.hit = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_q <= tok_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
